>>> hdl/particle_motion_step_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle motion step block
// Clocked property checks (PMS_ASSERT reset-qualified) that compile away with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_MOTION_STEP_TOP_DEFINES_SVH
`define PARTICLE_MOTION_STEP_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMS_ASSERT(label, clk, rst_n, prop, msg)
`define PMS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hdl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, codes and constants of the particle motion step block.
// ----------------------------------------------------------------------------
`default_nettype none
package pms_pkg;
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_FINAL = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] REG_MASS    = 3'd0;
    localparam logic [2:0] REG_DENSITY = 3'd1;
    localparam logic [2:0] REG_FX      = 3'd2;
    localparam logic [2:0] REG_FY      = 3'd3;
    localparam logic [2:0] REG_FZ      = 3'd4;
    localparam logic [2:0] REG_GX      = 3'd5;
    localparam logic [2:0] REG_GY      = 3'd6;
    localparam logic [2:0] REG_GZ      = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [30:0]        step_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] volume_in;
        logic signed [31:0] spin_in;
        logic signed [31:0] life_in;
        logic signed [31:0] angle_in;
    } t_in_word;

    typedef struct packed {
        logic               alive;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic signed [31:0] out_volume;
        logic signed [31:0] out_spin;
        logic signed [31:0] out_angle;
        logic [30:0]        life_left;
    } t_out_word;

    // Datapath micro-operations, one per controller state.
    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_ANG, S_VOLN, S_VOLD, S_SPNN, S_SPND, S_LIFE,
        S_FA, S_FAD, S_GA, S_K, S_K2, S_K2D, S_GK, S_ADD, S_POS, S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        t_state     op;
        logic [1:0] axis;
        logic       div_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic dead;
        logic buoy;
        logic step;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/pms_div.sv
// ----------------------------------------------------------------------------
// pms_div
// Radix-2 signed divider, 64-bit dividend by 32-bit positive divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module pms_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic [31:0]        i_den,
    output logic                    o_busy,
    output logic signed [63:0]      o_quo
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic [33:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_q[63]} - {2'b0, r_den};
        n_q     = {r_q[62:0], ~w_trial[33]};
        n_rem   = w_trial[33] ? {r_rem[31:0], r_q[63]} : w_trial[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_neg <= i_num[63];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != 0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 0);
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

>>> hdl/pms_ctrl.sv
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer for load, step and result phases.
// ----------------------------------------------------------------------------
`default_nettype none
module pms_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_out_stall,
    input  wire pms_pkg::t_status   i_status,
    output pms_pkg::t_cmd           o_cmd,
    output logic                    o_in_stall,
    output logic                    o_out_valid
);
    pms_pkg::t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pms_pkg::S_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd.op = r_state;
        o_cmd.axis = r_axis;
        o_cmd.div_start = 1'b0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            pms_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    n_state = pms_pkg::S_LOAD;
                end
            end
            pms_pkg::S_LOAD: begin
                n_axis = '0;
                if (i_status.step && !i_status.dead) begin
                    n_state = pms_pkg::S_ANG;
                end else begin
                    n_state = pms_pkg::S_OUT;
                end
            end
            pms_pkg::S_ANG: n_state = pms_pkg::S_VOLN;
            pms_pkg::S_VOLN: begin
                o_cmd.div_start = 1'b1;
                n_state = pms_pkg::S_VOLD;
            end
            pms_pkg::S_VOLD: if (!i_status.div_busy) begin
                n_state = pms_pkg::S_SPNN;
            end
            pms_pkg::S_SPNN: begin
                o_cmd.div_start = 1'b1;
                n_state = pms_pkg::S_SPND;
            end
            pms_pkg::S_SPND: if (!i_status.div_busy) begin
                n_state = pms_pkg::S_LIFE;
            end
            pms_pkg::S_LIFE: n_state = pms_pkg::S_FA;
            pms_pkg::S_FA: begin
                o_cmd.div_start = 1'b1;
                n_state = pms_pkg::S_FAD;
            end
            pms_pkg::S_FAD: if (!i_status.div_busy) begin
                n_state = pms_pkg::S_GA;
            end
            pms_pkg::S_GA: n_state = i_status.buoy ? pms_pkg::S_K : pms_pkg::S_ADD;
            pms_pkg::S_K: begin
                o_cmd.div_start = 1'b1;
                n_state = pms_pkg::S_K2;
            end
            pms_pkg::S_K2: if (!i_status.div_busy) begin
                n_state = pms_pkg::S_K2D;
            end
            pms_pkg::S_K2D: n_state = pms_pkg::S_GK;
            pms_pkg::S_GK: n_state = pms_pkg::S_ADD;
            pms_pkg::S_ADD: n_state = pms_pkg::S_POS;
            pms_pkg::S_POS: n_state = pms_pkg::S_DONE;
            pms_pkg::S_DONE: begin
                if (r_axis == 2'd2) begin
                    n_state = pms_pkg::S_OUT;
                end else begin
                    n_axis = r_axis + 2'd1;
                    n_state = pms_pkg::S_FA;
                end
            end
            pms_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = pms_pkg::S_IDLE;
                end
            end
            default: n_state = pms_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/pms_dp.sv
// ----------------------------------------------------------------------------
// pms_dp
// Particle state, configuration registers and the shared step datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module pms_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire pms_pkg::t_in_word   i_word,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire pms_pkg::t_cmd       i_cmd,
    output pms_pkg::t_status         o_status,
    output pms_pkg::t_out_word       o_word
);
    localparam int F = pms_pkg::FRAC_BITS;

    logic [30:0]        r_mass;
    logic signed [31:0] r_dens;
    logic signed [31:0] r_frc [3];
    logic signed [31:0] r_grv [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_vol, r_spin, r_ang, r_tvol, r_tspin;
    logic [30:0]        r_life;
    pms_pkg::t_in_word  r_in;
    logic signed [31:0] r_fa, r_ga, r_k, r_k2, r_add;
    logic signed [63:0] r_prod;

    logic               w_start;
    logic signed [63:0] w_num, w_quo;
    logic [31:0]        w_den;
    logic               w_busy;
    logic signed [32:0] w_dt, w_life, w_t;
    logic signed [31:0] w_quo_sat;
    logic [1:0]         w_ax;
    logic signed [33:0] w_h;
    logic signed [66:0] w_hd;
    logic signed [63:0] w_m1;

    assign w_ax    = i_cmd.axis;
    assign w_dt    = {2'b0, r_in.step_time};
    assign w_life  = {2'b0, r_life};
    assign w_t     = w_life - w_dt;
    assign w_start = i_cmd.div_start;
    assign w_quo_sat = pms_pkg::sat32({{2{w_quo[63]}}, w_quo});

    // Multiplies, then scales down by 2^F truncating toward zero, saturated.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [65:0] q;
        p = 66'(a) * 66'(b);
        q = (p < 0) ? -((-p) >>> F) : (p >>> F);
        return pms_pkg::sat32(q);
    endfunction

    always_comb begin
        w_num = 64'sd0;
        w_den = (r_mass == 0) ? 32'd1 : {1'b0, r_mass};
        w_m1  = 64'sd0;
        unique case (i_cmd.op)
            pms_pkg::S_VOLN: begin
                w_num = 64'(r_vol * w_t + r_tvol * w_dt);
                w_den = {1'b0, r_life};
            end
            pms_pkg::S_SPNN: begin
                w_num = 64'(r_spin * w_t + r_tspin * w_dt);
                w_den = {1'b0, r_life};
            end
            pms_pkg::S_FA: w_num = 64'(r_frc[w_ax] * w_dt);
            pms_pkg::S_K:  w_num = 64'(r_k * w_dt);
            default: w_m1 = 64'sd0;
        endcase
    end

    assign w_h  = 34'(r_vel[w_ax]) + 34'(r_add / 2);
    assign w_hd = 67'(w_h) * 67'(w_dt);

    pms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= 31'(1 << F);
            r_dens <= '0;
            for (int i = 0; i < 3; i++) begin
                r_frc[i] <= '0;
                r_grv[i] <= '0;
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
            r_vol   <= 32'sd1 <<< F;
            r_tvol  <= 32'sd1 <<< F;
            r_spin  <= '0;
            r_tspin <= '0;
            r_ang   <= '0;
            r_life  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pms_pkg::REG_MASS:    r_mass <= i_cfg_data[30:0];
                    pms_pkg::REG_DENSITY: r_dens <= i_cfg_data;
                    pms_pkg::REG_FX:      r_frc[0] <= i_cfg_data;
                    pms_pkg::REG_FY:      r_frc[1] <= i_cfg_data;
                    pms_pkg::REG_FZ:      r_frc[2] <= i_cfg_data;
                    pms_pkg::REG_GX:      r_grv[0] <= i_cfg_data;
                    pms_pkg::REG_GY:      r_grv[1] <= i_cfg_data;
                    pms_pkg::REG_GZ:      r_grv[2] <= i_cfg_data;
                    default: r_dens <= r_dens;
                endcase
            end
            unique case (i_cmd.op)
                pms_pkg::S_LOAD: begin
                    unique case (r_in.mode)
                        pms_pkg::MODE_START: begin
                            r_pos[0] <= r_in.pos_x;
                            r_pos[1] <= r_in.pos_y;
                            r_pos[2] <= r_in.pos_z;
                            r_vel[0] <= r_in.vel_x;
                            r_vel[1] <= r_in.vel_y;
                            r_vel[2] <= r_in.vel_z;
                            r_vol  <= r_in.volume_in;
                            r_spin <= r_in.spin_in;
                            r_life <= r_in.life_in[31] ? '0 : r_in.life_in[30:0];
                        end
                        pms_pkg::MODE_FINAL: begin
                            r_tvol  <= r_in.volume_in;
                            r_tspin <= r_in.spin_in;
                            r_ang   <= r_in.angle_in;
                        end
                        pms_pkg::MODE_STEP: if (o_status.dead) begin
                            r_life <= '0;
                        end
                        default: r_life <= r_life;
                    endcase
                end
                pms_pkg::S_ANG:
                    r_ang <= pms_pkg::sat32(66'(r_ang) + 66'(qmul(r_spin, w_dt)));
                pms_pkg::S_VOLD: if (!w_busy) begin
                    r_prod <= w_quo;
                end
                pms_pkg::S_SPND: if (!w_busy) begin
                    r_spin <= w_quo_sat;
                end
                pms_pkg::S_LIFE: begin
                    r_vol  <= pms_pkg::sat32({{2{r_prod[63]}}, r_prod});
                    r_life <= w_t[30:0];
                end
                pms_pkg::S_FAD: if (!w_busy) begin
                    r_fa <= w_quo_sat;
                end
                pms_pkg::S_GA: begin
                    r_ga <= qmul(r_grv[w_ax], w_dt);
                    r_k  <= qmul(r_dens, 33'(r_vol));
                end
                pms_pkg::S_K2: if (!w_busy) begin
                    r_k2 <= w_quo_sat;
                end
                pms_pkg::S_K2D: r_k2 <= qmul(r_grv[w_ax], 33'(r_k2));
                pms_pkg::S_GK:
                    r_ga <= pms_pkg::sat32(66'(r_ga) - 66'(r_k2));
                pms_pkg::S_ADD:
                    r_add <= pms_pkg::sat32(66'(r_fa) + 66'(r_ga));
                pms_pkg::S_POS: begin
                    r_pos[w_ax] <= pms_pkg::sat32(66'(r_pos[w_ax]) +
                        66'((w_hd < 0) ? -((-w_hd) >>> F) : (w_hd >>> F)));
                    r_vel[w_ax] <= pms_pkg::sat32(66'(r_vel[w_ax]) + 66'(r_add));
                end
                default: r_prod <= r_prod;
            endcase
        end
        if (i_accept) begin
            r_in <= i_word;
        end
    end

    assign o_status.div_busy = w_busy | w_start | (w_m1 != 0);
    assign o_status.dead = (r_life == 0) || ({2'b0, r_in.step_time} > w_life);
    assign o_status.buoy = (r_dens > 0);
    assign o_status.step = (r_in.mode == pms_pkg::MODE_STEP);

    assign o_word.alive      = (r_life != 0);
    assign o_word.out_pos_x  = r_pos[0];
    assign o_word.out_pos_y  = r_pos[1];
    assign o_word.out_pos_z  = r_pos[2];
    assign o_word.out_vel_x  = r_vel[0];
    assign o_word.out_vel_y  = r_vel[1];
    assign o_word.out_vel_z  = r_vel[2];
    assign o_word.out_volume = r_vol;
    assign o_word.out_spin   = r_spin;
    assign o_word.out_angle  = r_ang;
    assign o_word.life_left  = r_life;
endmodule
`default_nettype wire

>>> hdl/particle_motion_step_top.sv
// A load, a dead step or a word of mode NONE goes straight to the result; a live
// step runs the shared radix-2 divider for each quotient, 5 quotients per step
// without buoyancy and 8 with it. A stalled result is held until it is read.
// One word in flight at a time; the next is taken once the result is read.
// Reset (synchronous, active low) restores the particle and register defaults.
// ----------------------------------------------------------------------------
// particle_motion_step_top
// Fixed-point motion step of one particle (position from the mid-step velocity) with controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_motion_step_top_defines.svh"
module particle_motion_step_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire pms_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output pms_pkg::t_out_word      o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    pms_pkg::t_cmd    w_cmd;
    pms_pkg::t_status w_status;
    logic             w_accept;

    // Hold the word only when the controller is idle.
    assign w_accept = i_valid & ~o_stall;

    // The controller decides on the held word's mode through the status bits.
    pms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    pms_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_word     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_word     (o_data)
    );

    // Result and input sides never both open.
    `PMS_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_valid && !o_stall), "in/out overlap")
    // Accepting a word leaves the idle state next cycle.
    `PMS_ASSERT(a_busy_after, i_clk, i_rst_n, w_accept |=> o_stall, "stall missing")
    // Alive bit agrees with life.
    `PMS_ASSERT(a_alive, i_clk, i_rst_n,
        o_valid |-> (o_data.alive == (o_data.life_left != 0)), "alive mismatch")
endmodule
`default_nettype wire

>>> tb/sv/particle_motion_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_step_checker
// Watches both channels of the particle motion step block and the register
// write port. Keeps its own copy of the particle state and registers, works
// out the result word for every accepted input word and compares it field by
// field with the word the block delivers.
// ----------------------------------------------------------------------------
module particle_motion_step_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    input  pms_pkg::t_in_word   i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pms_pkg::t_out_word  i_out_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import pms_pkg::*;

    localparam longint QONE = longint'(1) << FRAC_BITS;

    logic [30:0]        mass_q;
    logic signed [31:0] density_q;
    logic signed [31:0] force_q [3];
    logic signed [31:0] grav_q [3];

    logic signed [31:0] pos_q [3];
    logic signed [31:0] vel_q [3];
    logic signed [31:0] volume_q, spin_q, angle_q;
    logic [30:0]        life_q;
    logic signed [31:0] final_volume_q, final_spin_q;

    t_out_word expected_words[$];

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input longint a, input longint b);
        return clamp32((a * b) / QONE);
    endfunction

    function automatic logic signed [31:0] lerp(input longint cur, input longint fin,
                                                input longint rest, input longint dt,
                                                input longint span);
        return clamp32((cur * rest + fin * dt) / span);
    endfunction

    task automatic reset_particle();
        mass_q = 31'(QONE);
        density_q = '0;
        for (int i = 0; i < 3; i++) begin
            force_q[i] = '0;
            grav_q[i] = '0;
            pos_q[i] = '0;
            vel_q[i] = '0;
        end
        volume_q = 32'(QONE);
        spin_q = '0;
        angle_q = '0;
        life_q = '0;
        final_volume_q = 32'(QONE);
        final_spin_q = '0;
    endtask

    // Apply one input word to the particle copy and queue the result word.
    task automatic advance_particle(input t_in_word w);
        longint span, dt, rest, mass, fa, ga, k, k2, add, mid;
        t_out_word r;
        dt = longint'(w.step_time);
        case (w.mode)
            MODE_START: begin
                pos_q[0] = w.pos_x; pos_q[1] = w.pos_y; pos_q[2] = w.pos_z;
                vel_q[0] = w.vel_x; vel_q[1] = w.vel_y; vel_q[2] = w.vel_z;
                volume_q = w.volume_in;
                spin_q = w.spin_in;
                life_q = (w.life_in < 0) ? 31'd0 : w.life_in[30:0];
            end
            MODE_FINAL: begin
                final_volume_q = w.volume_in;
                final_spin_q = w.spin_in;
                angle_q = w.angle_in;
            end
            MODE_STEP: begin
                if (life_q == 0 || w.step_time > life_q) begin
                    life_q = '0;
                end else begin
                    span = longint'(life_q);
                    rest = span - dt;
                    mass = (mass_q == 0) ? 64'sd1 : longint'(mass_q);
                    angle_q = clamp32(longint'(angle_q) +
                                      longint'(fx_mul(longint'(spin_q), dt)));
                    volume_q = lerp(longint'(volume_q), longint'(final_volume_q),
                                    rest, dt, span);
                    spin_q = lerp(longint'(spin_q), longint'(final_spin_q), rest, dt, span);
                    life_q = rest[30:0];
                    for (int i = 0; i < 3; i++) begin
                        fa = longint'(clamp32((longint'(force_q[i]) * dt) / mass));
                        ga = longint'(fx_mul(longint'(grav_q[i]), dt));
                        if (density_q > 0) begin
                            k = longint'(fx_mul(longint'(density_q), longint'(volume_q)));
                            k2 = longint'(clamp32((k * dt) / mass));
                            ga = longint'(clamp32(ga -
                                     longint'(fx_mul(longint'(grav_q[i]), k2))));
                        end
                        add = longint'(clamp32(fa + ga));
                        mid = longint'(vel_q[i]) + add / 64'sd2;
                        pos_q[i] = clamp32(longint'(pos_q[i]) + (mid * dt) / QONE);
                        vel_q[i] = clamp32(longint'(vel_q[i]) + add);
                    end
                end
            end
            default: ;
        endcase
        r.alive = (life_q != 0);
        r.out_pos_x = pos_q[0]; r.out_pos_y = pos_q[1]; r.out_pos_z = pos_q[2];
        r.out_vel_x = vel_q[0]; r.out_vel_y = vel_q[1]; r.out_vel_z = vel_q[2];
        r.out_volume = volume_q;
        r.out_spin = spin_q;
        r.out_angle = angle_q;
        r.life_left = life_q;
        expected_words.push_back(r);
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word exp_w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            o_errors++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
            o_errors++;
            if (got.alive !== exp_w.alive)
                $display("%0t: alive exp %0d got %0d", $time, exp_w.alive, got.alive);
            if (got.out_pos_x !== exp_w.out_pos_x)
                $display("%0t: pos_x exp %0d got %0d", $time, exp_w.out_pos_x, got.out_pos_x);
            if (got.out_pos_y !== exp_w.out_pos_y)
                $display("%0t: pos_y exp %0d got %0d", $time, exp_w.out_pos_y, got.out_pos_y);
            if (got.out_pos_z !== exp_w.out_pos_z)
                $display("%0t: pos_z exp %0d got %0d", $time, exp_w.out_pos_z, got.out_pos_z);
            if (got.out_vel_x !== exp_w.out_vel_x)
                $display("%0t: vel_x exp %0d got %0d", $time, exp_w.out_vel_x, got.out_vel_x);
            if (got.out_vel_y !== exp_w.out_vel_y)
                $display("%0t: vel_y exp %0d got %0d", $time, exp_w.out_vel_y, got.out_vel_y);
            if (got.out_vel_z !== exp_w.out_vel_z)
                $display("%0t: vel_z exp %0d got %0d", $time, exp_w.out_vel_z, got.out_vel_z);
            if (got.out_volume !== exp_w.out_volume)
                $display("%0t: volume exp %0d got %0d", $time, exp_w.out_volume,
                         got.out_volume);
            if (got.out_spin !== exp_w.out_spin)
                $display("%0t: spin exp %0d got %0d", $time, exp_w.out_spin, got.out_spin);
            if (got.out_angle !== exp_w.out_angle)
                $display("%0t: angle exp %0d got %0d", $time, exp_w.out_angle, got.out_angle);
            if (got.life_left !== exp_w.life_left)
                $display("%0t: life exp %0d got %0d", $time, exp_w.life_left, got.life_left);
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        reset_particle();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_particle();
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MASS:    mass_q = i_cfg_data[30:0];
                    REG_DENSITY: density_q = i_cfg_data;
                    REG_FX:      force_q[0] = i_cfg_data;
                    REG_FY:      force_q[1] = i_cfg_data;
                    REG_FZ:      force_q[2] = i_cfg_data;
                    REG_GX:      grav_q[0] = i_cfg_data;
                    REG_GY:      grav_q[1] = i_cfg_data;
                    REG_GZ:      grav_q[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_word(i_out_word);
            if (i_valid && !i_stall) advance_particle(i_in_word);
        end
        o_pending = expected_words.size();
    end
endmodule

>>> tb/sv/particle_motion_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_step_top_tb
// Drives the particle motion step block with directed and random words,
// walks the registers through several settings and gives the verdict.
// ----------------------------------------------------------------------------
module particle_motion_step_top_tb;
    import pms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    bit          stall_bursty;

    // 20 ns clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    particle_motion_step_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_data     (in_word),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    particle_motion_step_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_stall     (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver stall pattern: phases of heavy stalling alternate with phases
    // of none, so result words land on every phase of the block.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_bursty = ~stall_bursty;
            out_stall <= stall_bursty ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
    end

    // Pick a value biased toward the Q16.16 extremes.
    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            default: return $urandom;
        endcase
    endfunction

    // Modest physical value: keeps long live sequences away from saturation.
    function automatic logic [31:0] mild_word();
        return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
    endfunction

    // Hand one word to the block; hold it until accepted. Valid stays up for
    // a following word; a gap or a drain drops it.
    task automatic send_word(input t_in_word w);
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Gap after a burst of words, drawn at random.
    task automatic idle_gap(inout int burst_left);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 8);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Let every result come back, then hold for the tail of a dead-step run.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write enable stays up across back-to-back writes; write_all drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic write_all(input int flavor);
        logic [31:0] m;
        m = (flavor == 0) ? 32'h00010000 : (flavor == 1) ? 32'h7fffffff :
            (flavor == 2) ? 32'h0 : 32'h00000001;
        if (flavor > 3) m = $urandom_range(1, 32'h00100000);
        write_reg(REG_MASS, m);
        write_reg(REG_DENSITY, (flavor == 1) ? 32'h7fffffff : (flavor == 2) ? 32'h80000000 :
                  (flavor == 3) ? 32'h1 : (flavor > 3) ? mild_word() : 32'h0);
        write_reg(REG_FX, (flavor == 1) ? 32'h7fffffff : (flavor > 3) ? mild_word() : 32'h0);
        write_reg(REG_FY, (flavor == 1) ? 32'h80000000 : (flavor > 3) ? mild_word() : 32'h0);
        write_reg(REG_FZ, (flavor == 3) ? 32'h00020000 : (flavor > 3) ? edge_word() : 32'h0);
        write_reg(REG_GX, (flavor == 1) ? 32'h80000000 : (flavor > 3) ? mild_word() : 32'h0);
        write_reg(REG_GY, (flavor == 1) ? 32'h7fffffff : (flavor > 3) ? mild_word()
                                                                     : 32'hfff63d71);
        write_reg(REG_GZ, (flavor == 2) ? 32'h7fffffff : (flavor > 3) ? edge_word() : 32'h0);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_word make_word(input logic [1:0] mode, input bit mild);
        t_in_word w;
        logic [383:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        w.mode = mode;
        if (mild) begin
            w.pos_x = mild_word(); w.pos_y = mild_word(); w.pos_z = mild_word();
            w.vel_x = mild_word(); w.vel_y = mild_word(); w.vel_z = mild_word();
            w.volume_in = mild_word(); w.spin_in = mild_word(); w.angle_in = mild_word();
            w.life_in = $urandom_range(0, 32'h00200000);
            w.step_time = 31'($urandom_range(0, 32'h00008000));
        end else begin
            w.pos_x = edge_word(); w.vel_y = edge_word(); w.volume_in = edge_word();
            w.spin_in = edge_word(); w.life_in = edge_word(); w.angle_in = edge_word();
            w.step_time = 31'(edge_word());
        end
        return w;
    endfunction

    // Phase of random words: mostly a start load, a final load and a run of one to
    // ten steps, with some noise and broken sequences mixed in.
    task automatic random_phase(input int count);
        int burst;
        int sent;
        t_in_word w;
        burst = 0;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                send_word(make_word(MODE_START, 1'b1));
                idle_gap(burst);
                send_word(make_word(MODE_FINAL, 1'b1));
                idle_gap(burst);
                sent += 2;
                repeat ($urandom_range(1, 10)) begin
                    w = make_word(MODE_STEP, 1'b1);
                    if ($urandom_range(0, 15) == 0) w.step_time = 31'($urandom);
                    send_word(w);
                    idle_gap(burst);
                    sent++;
                end
            end else begin
                w = make_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                send_word(w);
                idle_gap(burst);
                sent++;
            end
        end
    endtask

    initial begin
        t_in_word w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_MASS;
        cfg_data = '0;
        stall_bursty = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: step from reset state (dead), negative life, loads, extremes.
        send_word(make_word(MODE_STEP, 1'b1));
        w = make_word(MODE_START, 1'b1);
        w.life_in = 32'h80000000;
        send_word(w);
        w = make_word(MODE_STEP, 1'b1);
        send_word(w);
        w = make_word(MODE_START, 1'b0);
        w.life_in = 32'h7fffffff;
        send_word(w);
        w = make_word(MODE_FINAL, 1'b0);
        send_word(w);
        w = make_word(MODE_STEP, 1'b0);
        w.step_time = 31'h7fffffff;
        send_word(w);
        w = make_word(MODE_NONE, 1'b0);
        send_word(w);
        // Life ends exactly, then one step past death.
        w = make_word(MODE_START, 1'b1);
        w.life_in = 32'h00010000;
        send_word(w);
        w.mode = MODE_STEP;
        w.step_time = 31'h00010000;
        send_word(w);
        w.step_time = 31'h0;
        send_word(w);
        // Live step with zero dt, then dt one above life.
        w = make_word(MODE_START, 1'b1);
        w.life_in = 32'h00020000;
        send_word(w);
        w.mode = MODE_STEP;
        w.step_time = 31'h0;
        send_word(w);
        w.step_time = 31'h00020001;
        send_word(w);
        drain();

        // Random phases over several register settings, extremes among them.
        for (int flavor = 0; flavor < 8; flavor++) begin
            write_all(flavor);
            stall_bursty = 1'($urandom_range(0, 1));
            random_phase(55);
            drain();
        end
        // Unused-looking mass of zero is covered by flavor 2 above.

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Live buoyant steps are the slowest; allow several times the slowest run of
    // ~500 words plus stalls.
    initial begin
        #(20 * 2000000);
        $display("FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/pms_pkg.sv
hdl/pms_div.sv
hdl/pms_ctrl.sv
hdl/pms_dp.sv
hdl/particle_motion_step_top.sv
tb/sv/particle_motion_step_checker.sv
tb/sv/particle_motion_step_top_tb.sv
